FILE: rtl/vtpd_pkg.sv
// Shared types and constants for the vertex transform with perspective divide.
// No dependencies.
package vtpd_pkg;

  localparam int unsigned NumRegs    = 8;
  localparam int unsigned RegWidth   = 64;
  localparam int unsigned RegIdxW    = 3;
  localparam int unsigned FieldWidth = 32;

  localparam logic [RegWidth-1:0] RegReset [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic w_was_zero;
    logic saturated;
  } flags_t;

endpackage

FILE: rtl/vtpd_divider.sv
// Pipelined signed restoring divider, one quotient bit per stage.
// Depends on vtpd_pkg.
module vtpd_divider import vtpd_pkg::*; #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32,
  parameter int unsigned TagW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic signed [DenW-1:0] den_i,
  input  logic [TagW-1:0]        tag_i,
  output logic                   valid_o,
  output logic signed [NumW:0]   quo_o,
  output logic [TagW-1:0]        tag_o
);

  localparam int unsigned RemW  = DenW + 1;
  localparam int unsigned Steps = NumW + 1;

  logic [NumW:0]   num_q [Steps+1];
  logic [RemW-1:0] rem_q [Steps+1];
  logic [DenW:0]   den_q [Steps+1];
  logic            neg_q [Steps+1];
  logic [TagW-1:0] tag_q [Steps+1];
  logic [Steps:0]  vld_q;

  logic [NumW:0] num_abs;
  logic [DenW:0] den_abs;
  assign num_abs = num_i[NumW-1] ? (NumW+1)'(-{num_i[NumW-1], num_i})
                                 : {1'b0, num_i};
  assign den_abs = den_i[DenW-1] ? (DenW+1)'(-{den_i[DenW-1], den_i})
                                 : {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0] <= num_abs;
      rem_q[0] <= '0;
      den_q[0] <= den_abs;
      neg_q[0] <= num_i[NumW-1] ^ den_i[DenW-1];
      tag_q[0] <= tag_i;
    end
  end

  for (genvar s = 0; s < Steps + 1; s++) begin : g_stage
    if (s > 0) begin : g_step
      logic [RemW:0] trial;
      logic [RemW:0] diff;
      assign trial = {rem_q[s-1], num_q[s-1][NumW]};
      assign diff  = trial - {1'b0, den_q[s-1]};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (!diff[RemW]) begin
            rem_q[s] <= diff[RemW-1:0];
            num_q[s] <= {num_q[s-1][NumW-1:0], 1'b1};
          end else begin
            rem_q[s] <= trial[RemW-1:0];
            num_q[s] <= {num_q[s-1][NumW-1:0], 1'b0};
          end
          den_q[s] <= den_q[s-1];
          neg_q[s] <= neg_q[s-1];
          tag_q[s] <= tag_q[s-1];
        end
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign quo_o   = neg_q[Steps] ? -$signed(num_q[Steps]) : $signed(num_q[Steps]);
  assign tag_o   = tag_q[Steps];

endmodule

FILE: rtl/vertex_transform_perspective_divide.sv
// Top level: 4x4 matrix times vertex in fixed point, with optional divide by w.
// Depends on vtpd_pkg and vtpd_divider.
//
// Usage: configure the matrix through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Register 2r+k holds row r, columns 2k (low half) and 2k+1 (high half).
// Vertices enter on s_axis (tdata = x, y, z, w; tuser = apply_divide) and
// results leave on m_axis (tdata = x, y, z, w; tuser = w_was_zero, saturated).
// Throughput: one vertex per cycle while the output is not stalled. Depth: 55
// register stages from input to output: 4 for the matrix product
// (multiply, add, add, shift/clamp), COORD_WIDTH+FRACTION_BITS+2 for the divider
// (input stage plus one quotient bit per stage, 50 by default) and one for the
// final clamp into the output register. The divider sets the depth.
// Reset clears all valid bits and restores the identity matrix.
// When m_axis_tready is low with a result waiting, the whole pipeline holds;
// s_axis_tready is high whenever the output stage is empty or being taken.
module vertex_transform_perspective_divide import vtpd_pkg::*; #(
  parameter int unsigned COORD_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [RegIdxW-1:0]     cfg_idx_i,
  input  logic [RegWidth-1:0]    cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [127:0]           s_axis_tdata,  // in_x, in_y, in_z, in_w
  input  logic                   s_axis_tuser,  // apply_divide
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [127:0]           m_axis_tdata,  // out_x, out_y, out_z, out_w
  output logic [1:0]             m_axis_tuser   // w_was_zero, saturated
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned PW   = 2 * CW;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned NumW = CW + FRACTION_BITS;
  localparam int unsigned TagW = 3 * CW + 3;
  localparam logic signed [SW-1:0] Hi = SW'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [SW-1:0] Lo = -Hi - SW'(1);
  localparam logic [31:0] One = 32'(64'd1 << FRACTION_BITS);
  localparam logic [RegWidth-1:0] RegInit [NumRegs] = '{
    {32'h0, One}, 64'h0,
    {One, 32'h0}, 64'h0,
    64'h0,        {32'h0, One},
    64'h0,        {One, 32'h0}
  };

  logic [RegWidth-1:0] regs_q [NumRegs];
  logic en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= RegInit;
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // stage 1: products
  logic signed [PW-1:0] prod_q [4][4];
  logic                 div_q [3];
  logic [3:0]           vld_q;
  logic signed [CW-1:0] vin [4];

  for (genvar c = 0; c < 4; c++) begin : g_vin
    assign vin[c] = $signed(s_axis_tdata[32*c +: CW]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[r][c] <= $signed(regs_q[2*r + c/2][32*(c%2) +: CW]) * vin[c];
        end
      end
    end
  end

  // stage 2 and 3: adds
  logic signed [SW-1:0] pair_q [4][2];
  logic signed [SW-1:0] sum_q  [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        pair_q[r][0] <= SW'(prod_q[r][0]) + SW'(prod_q[r][1]);
        pair_q[r][1] <= SW'(prod_q[r][2]) + SW'(prod_q[r][3]);
        sum_q[r]     <= pair_q[r][0] + pair_q[r][1];
      end
      div_q[0] <= s_axis_tuser;
      div_q[1] <= div_q[0];
      div_q[2] <= div_q[1];
    end
  end

  // stage 4: shift, clamp
  logic signed [CW-1:0] res_q [4];
  logic                 sat4_q;
  logic                 div4_q;
  always_ff @(posedge clk_i) begin
    logic signed [SW-1:0] sh;
    logic s;
    if (en) begin
      s = 1'b0;
      for (int r = 0; r < 4; r++) begin
        sh = sum_q[r] >>> FRACTION_BITS;
        if (sh > Hi) begin
          res_q[r] <= Hi[CW-1:0]; s = 1'b1;
        end else if (sh < Lo) begin
          res_q[r] <= Lo[CW-1:0]; s = 1'b1;
        end else begin
          res_q[r] <= sh[CW-1:0];
        end
      end
      sat4_q <= s;
      div4_q <= div_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[2:0], s_axis_tvalid && s_axis_tready};
    end
  end

  // three dividers in lockstep; tag carries passthrough data
  logic [TagW-1:0] tag_in, tag_out;
  logic signed [NumW:0] quo [3];
  logic dv [3];
  logic signed [CW-1:0] den;
  logic wz;
  assign wz     = (res_q[3] == '0);
  assign den    = wz ? CW'(1) : res_q[3];
  assign tag_in = {res_q[0], res_q[1], res_q[2], div4_q && !wz,
                   div4_q && wz, sat4_q};

  logic [TagW-1:0] tag_x [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    vtpd_divider #(.NumW(NumW), .DenW(CW), .TagW(TagW)) u_div (
      .clk_i, .rst_ni, .en_i(en), .valid_i(vld_q[3]),
      .num_i({res_q[i], FRACTION_BITS'(0)}), .den_i(den),
      .tag_i(i == 0 ? tag_in : {{(TagW-CW){1'b0}}, res_q[3]}),
      .valid_o(dv[i]), .quo_o(quo[i]), .tag_o(tag_x[i]));
  end
  assign tag_out = tag_x[0];

  // final clamp and output register
  logic                 ov_q;
  logic [127:0]         od_q;
  flags_t               of_q;
  assign en = !ov_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv[0];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] pv;
    logic s;
    if (en) begin
      s = tag_out[0];
      for (int i = 0; i < 3; i++) begin
        pv = $signed(tag_out[TagW-1-CW*i -: CW]);
        if (tag_out[2]) begin
          if (quo[i] > $signed((NumW+1)'(Hi))) begin
            pv = Hi[CW-1:0]; s = 1'b1;
          end else if (quo[i] < $signed((NumW+1)'(Lo))) begin
            pv = Lo[CW-1:0]; s = 1'b1;
          end else begin
            pv = quo[i][CW-1:0];
          end
        end
        od_q[32*i +: 32] <= 32'(pv);
      end
      od_q[96 +: 32] <= 32'($signed(tag_x[1][CW-1:0]));
      of_q.w_was_zero <= tag_out[1];
      of_q.saturated  <= s;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tuser  = {of_q.saturated, of_q.w_was_zero};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv[0] == dv[1]) && (dv[0] == dv[2]))
    else $error("divider lanes out of step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[127:96] == '0)
    else $error("zero-w flag with nonzero w");

endmodule

FILE: tb/tb.sv
// Testbench for vertex_transform_perspective_divide: random and directed vertices,
// checked against an in-bench fixed-point matrix/divide predictor.
// Depends on vtpd_pkg and the block's RTL.
`timescale 1ns / 100ps

class vertex_scoreboard;
  logic [63:0]  matrix [8];
  logic [127:0] want_data [$];
  logic [1:0]   want_flags [$];
  int           errors;
  int           checked;
  int           divides;
  int           zero_w;
  int           clamps;

  function new();
    for (int i = 0; i < 8; i++) matrix[i] = vtpd_pkg::RegReset[i];
    errors  = 0;
    checked = 0;
    divides = 0;
    zero_w  = 0;
    clamps  = 0;
  endfunction

  function longint clamp32(logic signed [65:0] a, inout bit sat);
    if (a > 66'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (a < -66'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return longint'(a);
  endfunction

  function void note_vertex(logic [127:0] d, logic apply_div);
    int                 v [4];
    int                 k;
    longint             res [4];
    longint             num;
    logic signed [65:0] acc;
    logic [127:0]       packed_res;
    bit                 sat;
    bit                 wz;
    sat = 0;
    wz  = 0;
    for (int i = 0; i < 4; i++) v[i] = d[32*i +: 32];
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++) begin
        k   = matrix[2*r + c/2][32*(c%2) +: 32];
        acc = acc + (longint'(k) * longint'(v[c]));
      end
      acc    = acc >>> 16;
      res[r] = clamp32(acc, sat);
    end
    if (apply_div) begin
      if (res[3] == 0) begin
        wz = 1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          num    = res[i] * 64'sd65536;
          res[i] = clamp32(num / res[3], sat);
        end
      end
      divides++;
    end
    if (wz) zero_w++;
    if (sat) clamps++;
    for (int i = 0; i < 4; i++) packed_res[32*i +: 32] = res[i][31:0];
    want_data.push_back(packed_res);
    want_flags.push_back({sat, wz});
  endfunction

  function void check_result(logic [127:0] d, logic [1:0] f);
    logic [127:0] wd;
    logic [1:0]   wf;
    checked++;
    if (want_data.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result data=%h flags=%b", d, f);
      return;
    end
    wd = want_data.pop_front();
    wf = want_flags.pop_front();
    if (d !== wd || f !== wf) begin
      errors++;
      if (errors <= 10)
        $display("mismatch #%0d: exp x=%h y=%h z=%h w=%h wz=%b sat=%b",
                 checked, wd[31:0], wd[63:32], wd[95:64], wd[127:96], wf[0], wf[1]);
      if (errors <= 10)
        $display("             got x=%h y=%h z=%h w=%h wz=%b sat=%b",
                 d[31:0], d[63:32], d[95:64], d[127:96], f[0], f[1]);
    end
  endfunction
endclass

module tb;
  import vtpd_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [RegIdxW-1:0]    cfg_idx_i;
  logic [RegWidth-1:0]   cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [127:0]          s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [127:0]          m_axis_tdata;
  logic [1:0]            m_axis_tuser;

  vertex_scoreboard      sb;
  int                    tx_idle;
  int                    rx_idle;
  bit                    hold_req;
  int                    hold_left;
  int                    cycles;
  int                    sent;

  vertex_transform_perspective_divide dut (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 500000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_vertex(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'h0001_0000;
      4, 5: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [31:0] w, logic dv);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w, z, y, x};
    s_axis_tuser  <= dv;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.want_data.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(int idx, logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx[RegIdxW-1:0];
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.matrix[idx] = val;
  endtask

  task automatic load_matrix(int kind);
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0: write_reg(i, {32'h7fff_ffff, 32'h7fff_ffff});
        1: write_reg(i, {32'h8000_0000, 32'h8000_0000});
        2: write_reg(i, RegReset[i]);
        3: write_reg(i, (i >= 6) ? 64'h0 : {rand_coord(), rand_coord()});
        4: write_reg(i, (i == 7) ? 64'h0001_0000_0000_0000 :
                        (i == 6) ? 64'h0 : {rand_coord(), rand_coord()});
        default: write_reg(i, {rand_coord(), rand_coord()});
      endcase
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    tx_idle       = 0;
    rx_idle       = 0;
    hold_req      = 0;
    hold_left     = 0;
    cycles        = 0;
    sent          = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity matrix after reset
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0002_0000, 1'b1);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 1'b1);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 1'b1);
    send_vertex(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0, 1'b1);
    send_vertex(32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0, 1'b0);
    send_vertex(32'h0003_0000, 32'hfff9_0000, 32'h0000_8000, 32'hfffe_0000, 1'b1);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_vertex(32'hffff_ffff, 32'h0000_0001, 32'hffff_ffff, 32'h0001_0000, 1'b1);
    drain();
    load_matrix(0);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
    send_vertex(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1);
    drain();
    load_matrix(1);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_0000, 1'b1);
    send_vertex(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      load_matrix((ph == 0) ? 2 : (ph == 2) ? 3 : (ph % 2) ? 4 : 5);
      case (ph % 3)
        0: begin tx_idle = 36; rx_idle = 64; end
        1: begin tx_idle = 64; rx_idle = 36; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      for (int n = 0; n < 330; n++) begin
        if (ph == 2 && n == 20) hold_req = 1;
        send_vertex(rand_coord(), rand_coord(), rand_coord(),
                    ($urandom_range(5) == 0) ? 32'h0 : rand_coord(),
                    $urandom_range(3) != 0);
      end
      drain();
    end

    $display("%0d vertices sent over 9 matrix settings; %0d with divide, %0d zero-w skips,",
             sent, sb.divides, sb.zero_w);
    $display("%0d saturated results, %0d results checked", sb.clamps, sb.checked);
    if (sb.errors == 0 && sb.want_data.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
